// ----- design/ssi_pkg.sv -----
// shared types and constants for the sphere/segment crossing pipeline
`timescale 1ns / 1ps

package ssi_pkg;

    localparam int COORD_W   = 32;
    localparam int DELTA_W   = 33;
    localparam int CFG_IDX_W = 3;
    localparam int A_W       = 62;
    localparam int H_W       = 63;
    localparam int PROD_W    = 124;
    localparam int SQ_RAD_W  = 126;
    localparam int SQ_ROOT_W = 63;
    localparam int DIV_Q_W   = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 3'd4;

    // 0.01 in Q16.16, used to widen the bounding box
    localparam logic [DELTA_W-1:0] BOX_MARGIN = 33'd655;
    // largest negative discriminant still treated as a tangent, units of 2^-56
    localparam logic [PROD_W:0] DISC_SLACK = 125'd180143985094819;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_HIT   = 2'd1,
        ST_FAULT = 2'd2
    } t_status;

    // what the final stage puts on the hit fields
    typedef enum logic [2:0] {
        K_NONE,
        K_FAULT,
        K_START,
        K_END,
        K_INTERP
    } t_kind;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
    } t_in;

    typedef struct packed {
        t_status                   status;
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic signed [COORD_W-1:0] hit_z;
    } t_out;

    typedef struct packed {
        t_kind                       kind;
        logic [A_W-1:0]              a;
        logic [H_W-1:0]              h;
        logic [2:0][COORD_W-1:0]     s;
        logic [2:0][DELTA_W-1:0]     vr;
    } t_sq_side;

    typedef struct packed {
        t_kind                       kind;
        logic [2:0][COORD_W-1:0]     s;
        logic [2:0][DELTA_W-1:0]     vr;
    } t_dv_side;

endpackage

// ----- design/ssi_sqrt_pipe.sv -----
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps

module ssi_sqrt_pipe (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  logic                             i_valid,
    input  logic [ssi_pkg::SQ_RAD_W-1:0]     i_rad,
    input  ssi_pkg::t_sq_side                i_side,
    output logic                             o_valid,
    output logic [ssi_pkg::SQ_ROOT_W-1:0]    o_root,
    output ssi_pkg::t_sq_side                o_side
);
    import ssi_pkg::*;

    localparam int N  = SQ_ROOT_W;
    localparam int RW = SQ_ROOT_W + 4;

    logic                r_v    [N];
    logic [RW-1:0]       r_rem  [N];
    logic [N-1:0]        r_root [N];
    logic [SQ_RAD_W-1:0] r_rad  [N];
    t_sq_side            r_side [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic                v_in;
        logic [RW-1:0]       rem_in;
        logic [N-1:0]        root_in;
        logic [SQ_RAD_W-1:0] rad_in;
        t_sq_side            side_in;
        logic [RW-1:0]       cur;
        logic [RW-1:0]       trial;
        logic                ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign side_in = r_side[k-1];
        end

        // bring down the next radicand bit pair, try root*4+1
        assign cur   = {rem_in[RW-3:0], rad_in[SQ_RAD_W-1 -: 2]};
        assign trial = RW'({root_in, 2'b01});
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_adv) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k]  <= ge ? (cur - trial) : cur;
                r_root[k] <= {root_in[N-2:0], ge};
                r_rad[k]  <= rad_in << 2;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

// ----- design/ssi_div_pipe.sv -----
// pipelined restoring divider for (un * 2^32) / ua with un <= ua
`timescale 1ns / 1ps

module ssi_div_pipe (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic                            i_valid,
    input  logic [ssi_pkg::COORD_W-1:0]     i_ua,
    input  logic [ssi_pkg::COORD_W-1:0]     i_un,
    input  ssi_pkg::t_dv_side               i_side,
    output logic                            o_valid,
    output logic [ssi_pkg::DIV_Q_W-1:0]     o_q,
    output ssi_pkg::t_dv_side               o_side
);
    import ssi_pkg::*;

    localparam int N = DIV_Q_W;
    localparam int W = COORD_W;

    logic         r_v    [N];
    logic [W-1:0] r_rem  [N];
    logic [W-1:0] r_ua   [N];
    logic [N-1:0] r_q    [N];
    t_dv_side     r_side [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic         v_in;
        logic [W-1:0] ua_in;
        logic [N-1:0] q_in;
        t_dv_side     side_in;
        logic [W:0]   cur;
        logic         ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign ua_in   = i_ua;
            assign q_in    = '0;
            assign side_in = i_side;
            assign cur     = {1'b0, i_un};
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign ua_in   = r_ua[k-1];
            assign q_in    = r_q[k-1];
            assign side_in = r_side[k-1];
            assign cur     = {r_rem[k-1], 1'b0};
        end

        assign ge = (cur >= {1'b0, ua_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_adv) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k]  <= ge ? W'(cur - {1'b0, ua_in}) : W'(cur);
                r_ua[k]   <= ua_in;
                r_q[k]    <= {q_in[N-2:0], ge};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_q     = r_q[N-1];
    assign o_side  = r_side[N-1];

endmodule

// ----- design/sphere_segment_intersect.sv -----
// top level: segment against sphere crossing point, fully pipelined
`timescale 1ns / 1ps

// sphere_segment_intersect
// input channel: one segment (start and end point, Q16.16) per transfer on
//   i_in_valid / o_in_stall with payload i_in_data
// output channel: one result per segment on o_out_valid / i_out_stall with
//   payload o_out_data (status and crossing point)
// config channel: i_cfg_valid / o_cfg_ready write centre, radius and inside
//   tolerance by index; o_cfg_ready is always high, write only while idle
// throughput: one segment per cycle while i_out_stall does not hold the pipeline
// depth: the bulk of the pipeline is the 63-stage square root (one root bit per
//   stage) and the 33-stage divider (one quotient bit per stage)
// reset: synchronous active low, empties the pipeline and loads the register
//   defaults (centre 0, radius 1.0, tolerance 0)
// stall: while a result waits with i_out_stall high the whole pipeline holds
//   and o_in_stall is raised; nothing is dropped or repeated
module sphere_segment_intersect (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  ssi_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ssi_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ssi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);
    import ssi_pkg::*;

    // ---------------- configuration registers
    logic signed [COORD_W-1:0] r_c [3];
    logic [30:0]               r_rad;
    logic [30:0]               r_tol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c[0] <= '0;
            r_c[1] <= '0;
            r_c[2] <= '0;
            r_rad  <= 31'd65536;
            r_tol  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CENTRE_X: r_c[0] <= i_cfg_data;
                CFG_CENTRE_Y: r_c[1] <= i_cfg_data;
                CFG_CENTRE_Z: r_c[2] <= i_cfg_data;
                CFG_RADIUS:   r_rad  <= i_cfg_data[30:0];
                CFG_TOL:      r_tol  <= i_cfg_data[30:0];
                default:      ;
            endcase
        end
    end

    // ---------------- flow control: whole pipeline moves together
    logic adv;
    logic r_out_valid;
    t_out r_out;

    assign adv         = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- stage 1: differences, bounding box, quarter deltas
    logic signed [COORD_W-1:0] w_s [3];
    logic signed [COORD_W-1:0] w_e [3];

    assign w_s[0] = i_in_data.start_x;
    assign w_s[1] = i_in_data.start_y;
    assign w_s[2] = i_in_data.start_z;
    assign w_e[0] = i_in_data.end_x;
    assign w_e[1] = i_in_data.end_y;
    assign w_e[2] = i_in_data.end_z;

    logic signed [DELTA_W-1:0] c1_dxs [3];
    logic signed [DELTA_W-1:0] c1_dxe [3];
    logic signed [DELTA_W-1:0] c1_vr  [3];
    logic [DELTA_W-1:0]        c1_ms  [3];
    logic [DELTA_W-1:0]        c1_me  [3];
    logic [DELTA_W-1:0]        c1_span;
    logic                      c1_box_s;
    logic                      c1_box_e;

    always_comb begin
        c1_span  = {2'b00, r_rad} + BOX_MARGIN;
        c1_box_s = 1'b1;
        c1_box_e = 1'b1;
        for (int i = 0; i < 3; i++) begin
            c1_dxs[i] = {w_s[i][31], w_s[i]} - {r_c[i][31], r_c[i]};
            c1_dxe[i] = {w_e[i][31], w_e[i]} - {r_c[i][31], r_c[i]};
            c1_vr[i]  = {w_e[i][31], w_e[i]} - {w_s[i][31], w_s[i]};
            c1_ms[i]  = c1_dxs[i][32] ? $unsigned(-c1_dxs[i]) : $unsigned(c1_dxs[i]);
            c1_me[i]  = c1_dxe[i][32] ? $unsigned(-c1_dxe[i]) : $unsigned(c1_dxe[i]);
            if (c1_ms[i] > c1_span) begin
                c1_box_s = 1'b0;
            end
            if (c1_me[i] > c1_span) begin
                c1_box_e = 1'b0;
            end
        end
    end

    logic                      r1_v;
    logic [2:0][COORD_W-1:0]   r1_s;
    logic [2:0][DELTA_W-1:0]   r1_vr;
    logic [COORD_W-1:0]        r1_ms [3];
    logic [COORD_W-1:0]        r1_me [3];
    logic signed [30:0]        r1_dq [3];
    logic signed [30:0]        r1_vq [3];
    logic                      r1_box_s;
    logic                      r1_box_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r1_s[i]  <= w_s[i];
                r1_vr[i] <= c1_vr[i];
                // a miss in the box makes the squares irrelevant
                r1_ms[i] <= c1_ms[i][31:0];
                r1_me[i] <= c1_me[i][31:0];
                r1_dq[i] <= c1_dxs[i][32:2];
                r1_vq[i] <= c1_vr[i][32:2];
            end
            r1_box_s <= c1_box_s;
            r1_box_e <= c1_box_e;
        end
    end

    // ---------------- stage 2: all the narrow products
    logic                      r2_v;
    logic [2:0][COORD_W-1:0]   r2_s;
    logic [2:0][DELTA_W-1:0]   r2_vr;
    logic [63:0]               r2_ms2 [3];
    logic [63:0]               r2_me2 [3];
    logic signed [61:0]        r2_vv  [3];
    logic signed [61:0]        r2_dv  [3];
    logic signed [61:0]        r2_dd  [3];
    logic [57:0]               r2_rq2;
    logic [61:0]               r2_rr;
    logic                      r2_box_s;
    logic                      r2_box_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (adv) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r2_ms2[i] <= r1_ms[i] * r1_ms[i];
                r2_me2[i] <= r1_me[i] * r1_me[i];
                r2_vv[i]  <= r1_vq[i] * r1_vq[i];
                r2_dv[i]  <= r1_dq[i] * r1_vq[i];
                r2_dd[i]  <= r1_dq[i] * r1_dq[i];
            end
            r2_rq2   <= r_rad[30:2] * r_rad[30:2];
            r2_rr    <= r_rad * r_rad;
            r2_s     <= r1_s;
            r2_vr    <= r1_vr;
            r2_box_s <= r1_box_s;
            r2_box_e <= r1_box_e;
        end
    end

    // ---------------- stage 3: inside tests, quadratic coefficients
    logic [65:0]        c3_d2s;
    logic [65:0]        c3_d2e;
    logic [65:0]        c3_lim;
    logic               c3_cross;
    logic [A_W-1:0]     c3_a;
    logic signed [H_W-1:0] c3_h;
    logic [61:0]        c3_dd;
    logic signed [H_W-1:0] c3_cc;
    t_kind              c3_kind;

    always_comb begin
        c3_d2s = 66'(r2_ms2[0]) + 66'(r2_ms2[1]) + 66'(r2_ms2[2]);
        c3_d2e = 66'(r2_me2[0]) + 66'(r2_me2[1]) + 66'(r2_me2[2]);
        c3_lim = 66'(r2_rr) + 66'({r_tol, 16'h0000});
        c3_cross = (r2_box_s && (c3_d2s <= c3_lim)) != (r2_box_e && (c3_d2e <= c3_lim));
        c3_a  = $unsigned(r2_vv[0]) + $unsigned(r2_vv[1]) + $unsigned(r2_vv[2]);
        c3_h  = {r2_dv[0][61], r2_dv[0]} + {r2_dv[1][61], r2_dv[1]}
              + {r2_dv[2][61], r2_dv[2]};
        c3_dd = $unsigned(r2_dd[0]) + $unsigned(r2_dd[1]) + $unsigned(r2_dd[2]);
        c3_cc = $signed({1'b0, c3_dd}) - $signed({5'b00000, r2_rq2});
        if (!c3_cross) begin
            c3_kind = K_NONE;
        end else if (c3_a == '0) begin
            // endpoints too close together: answer is the start point
            c3_kind = K_START;
        end else begin
            c3_kind = K_INTERP;
        end
    end

    logic                      r3_v;
    logic [2:0][COORD_W-1:0]   r3_s;
    logic [2:0][DELTA_W-1:0]   r3_vr;
    logic [A_W-1:0]            r3_a;
    logic signed [H_W-1:0]     r3_h;
    logic signed [H_W-1:0]     r3_cc;
    t_kind                     r3_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (adv) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_s    <= r2_s;
            r3_vr   <= r2_vr;
            r3_a    <= c3_a;
            r3_h    <= c3_h;
            r3_cc   <= c3_cc;
            r3_kind <= c3_kind;
        end
    end

    // ---------------- stage 4: magnitudes for the wide products
    logic                      r4_v;
    logic [2:0][COORD_W-1:0]   r4_s;
    logic [2:0][DELTA_W-1:0]   r4_vr;
    logic [A_W-1:0]            r4_a;
    logic signed [H_W-1:0]     r4_h;
    logic [61:0]               r4_hm;
    logic [61:0]               r4_cm;
    logic                      r4_ccpos;
    t_kind                     r4_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (adv) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_hm    <= r3_h[H_W-1] ? 62'($unsigned(-r3_h)) : 62'($unsigned(r3_h));
            r4_cm    <= r3_cc[H_W-1] ? 62'($unsigned(-r3_cc)) : 62'($unsigned(r3_cc));
            r4_ccpos <= !r3_cc[H_W-1] && (r3_cc != '0);
            r4_s     <= r3_s;
            r4_vr    <= r3_vr;
            r4_a     <= r3_a;
            r4_h     <= r3_h;
            r4_kind  <= r3_kind;
        end
    end

    // ---------------- stage 5: partial products of h*h and a*|c|
    logic                      r5_v;
    logic [2:0][COORD_W-1:0]   r5_s;
    logic [2:0][DELTA_W-1:0]   r5_vr;
    logic [A_W-1:0]            r5_a;
    logic signed [H_W-1:0]     r5_h;
    logic                      r5_ccpos;
    t_kind                     r5_kind;
    logic [61:0]               r5_hll, r5_hlh, r5_hhh;
    logic [61:0]               r5_acll, r5_aclh, r5_achl, r5_achh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (adv) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_hll   <= r4_hm[30:0]  * r4_hm[30:0];
            r5_hlh   <= r4_hm[30:0]  * r4_hm[61:31];
            r5_hhh   <= r4_hm[61:31] * r4_hm[61:31];
            r5_acll  <= r4_a[30:0]   * r4_cm[30:0];
            r5_aclh  <= r4_a[30:0]   * r4_cm[61:31];
            r5_achl  <= r4_a[61:31]  * r4_cm[30:0];
            r5_achh  <= r4_a[61:31]  * r4_cm[61:31];
            r5_s     <= r4_s;
            r5_vr    <= r4_vr;
            r5_a     <= r4_a;
            r5_h     <= r4_h;
            r5_ccpos <= r4_ccpos;
            r5_kind  <= r4_kind;
        end
    end

    // ---------------- stage 6: assemble the 124-bit products
    logic                      r6_v;
    logic [2:0][COORD_W-1:0]   r6_s;
    logic [2:0][DELTA_W-1:0]   r6_vr;
    logic [A_W-1:0]            r6_a;
    logic signed [H_W-1:0]     r6_h;
    logic                      r6_ccpos;
    t_kind                     r6_kind;
    logic [PROD_W-1:0]         r6_h2;
    logic [PROD_W-1:0]         r6_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (adv) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // cross term appears twice in a square, hence the shift by 32
            r6_h2 <= (PROD_W'(r5_hhh) << 62) + (PROD_W'(r5_hlh) << 32) + PROD_W'(r5_hll);
            r6_ac <= (PROD_W'(r5_achh) << 62)
                   + ((PROD_W'(r5_aclh) + PROD_W'(r5_achl)) << 31)
                   + PROD_W'(r5_acll);
            r6_s     <= r5_s;
            r6_vr    <= r5_vr;
            r6_a     <= r5_a;
            r6_h     <= r5_h;
            r6_ccpos <= r5_ccpos;
            r6_kind  <= r5_kind;
        end
    end

    // ---------------- stage 7: discriminant and fault check
    logic [PROD_W:0] c7_sum;
    logic [PROD_W:0] c7_diff;
    logic [PROD_W:0] c7_negd;
    logic [PROD_W:0] c7_disc;
    t_kind           c7_kind;

    always_comb begin
        c7_sum  = {1'b0, r6_h2} + {1'b0, r6_ac};
        c7_diff = {1'b0, r6_h2} - {1'b0, r6_ac};
        c7_negd = {1'b0, r6_ac} - {1'b0, r6_h2};
        c7_kind = r6_kind;
        if (!r6_ccpos) begin
            c7_disc = c7_sum;
        end else if (!c7_diff[PROD_W]) begin
            c7_disc = c7_diff;
        end else begin
            // slightly negative counts as a tangent, more is a fault
            c7_disc = '0;
            if (r6_kind == K_INTERP && c7_negd > DISC_SLACK) begin
                c7_kind = K_FAULT;
            end
        end
    end

    logic              r7_v;
    logic [PROD_W:0]   r7_disc;
    t_sq_side          r7_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (adv) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r7_disc      <= c7_disc;
            r7_side.kind <= c7_kind;
            r7_side.a    <= r6_a;
            r7_side.h    <= r6_h;
            r7_side.s    <= r6_s;
            r7_side.vr   <= r6_vr;
        end
    end

    // ---------------- square root
    logic                  sq_v;
    logic [SQ_ROOT_W-1:0]  sq_root;
    t_sq_side              sq_side;

    ssi_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r7_v),
        .i_rad   ({1'b0, r7_disc}),
        .i_side  (r7_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // ---------------- stage 8: root selection and clamping
    logic signed [65:0] c8_nh;
    logic signed [65:0] c8_np;
    logic signed [65:0] c8_nm;
    logic signed [65:0] c8_a;
    logic signed [65:0] c8_dp;
    logic signed [65:0] c8_dm;
    logic signed [65:0] c8_pick;
    logic [A_W-1:0]     c8_num;
    t_kind              c8_kind;

    always_comb begin
        c8_nh   = -{{3{sq_side.h[H_W-1]}}, sq_side.h};
        c8_np   = c8_nh + $signed({3'b000, sq_root});
        c8_nm   = c8_nh - $signed({3'b000, sq_root});
        c8_a    = $signed({4'b0000, sq_side.a});
        c8_dp   = c8_np[65] ? -c8_np : (c8_np - c8_a);
        c8_dm   = c8_nm[65] ? -c8_nm : (c8_nm - c8_a);
        c8_pick = (c8_dp < c8_dm) ? c8_np : c8_nm;
        c8_kind = sq_side.kind;
        c8_num  = '0;
        if (!c8_np[65] && c8_np <= c8_a) begin
            c8_num = c8_np[A_W-1:0];
        end else if (!c8_nm[65] && c8_nm <= c8_a) begin
            c8_num = c8_nm[A_W-1:0];
        end else if (sq_side.kind == K_INTERP) begin
            // no root on the segment: snap to the nearer endpoint
            c8_kind = (c8_pick > c8_a) ? K_END : K_START;
        end
    end

    logic                      r8_v;
    logic [A_W-1:0]            r8_num;
    logic [A_W-1:0]            r8_a;
    t_dv_side                  r8_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (adv) begin
            r8_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r8_num       <= c8_num;
            r8_a         <= sq_side.a;
            r8_side.kind <= c8_kind;
            r8_side.s    <= sq_side.s;
            r8_side.vr   <= sq_side.vr;
        end
    end

    // ---------------- stage 9: normalize shift so the divisor fits 32 bits
    logic [6:0] c9_len;
    logic [4:0] c9_sh;

    always_comb begin
        c9_len = '0;
        for (int i = 0; i < A_W; i++) begin
            if (r8_a[i]) begin
                c9_len = 7'(i + 1);
            end
        end
        c9_sh = (c9_len > 7'd32) ? 5'(c9_len - 7'd32) : 5'd0;
    end

    logic           r9_v;
    logic [A_W-1:0] r9_num;
    logic [A_W-1:0] r9_a;
    logic [4:0]     r9_sh;
    t_dv_side       r9_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (adv) begin
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r9_num  <= r8_num;
            r9_a    <= r8_a;
            r9_sh   <= c9_sh;
            r9_side <= r8_side;
        end
    end

    // ---------------- stage 10: apply the shift
    logic               r10_v;
    logic [COORD_W-1:0] r10_ua;
    logic [COORD_W-1:0] r10_un;
    t_dv_side           r10_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else if (adv) begin
            r10_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r10_ua   <= COORD_W'(r9_a >> r9_sh);
            r10_un   <= COORD_W'(r9_num >> r9_sh);
            r10_side <= r9_side;
        end
    end

    // ---------------- segment parameter as a 1.32 fraction (up to 1.0)
    logic               dv_v;
    logic [DIV_Q_W-1:0] dv_q;
    t_dv_side           dv_side;

    ssi_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r10_v),
        .i_ua    (r10_ua),
        .i_un    (r10_un),
        .i_side  (r10_side),
        .o_valid (dv_v),
        .o_q     (dv_q),
        .o_side  (dv_side)
    );

    // ---------------- stage 11: parameter times |end - start| per axis
    logic [DELTA_W-1:0] c11_vm [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c11_vm[i] = dv_side.vr[i][32] ? (~dv_side.vr[i] + 33'd1) : dv_side.vr[i];
        end
    end

    logic                    r11_v;
    logic [65:0]             r11_prod [3];
    t_dv_side                r11_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
        end else if (adv) begin
            r11_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r11_prod[i] <= dv_q * c11_vm[i];
            end
            r11_side <= dv_side;
        end
    end

    // ---------------- stage 12: rounding, offset from start, output register
    logic [COORD_W-1:0] c12_hit [3];
    logic [COORD_W-1:0] c12_end [3];
    logic [65:0]        c12_rnd [3];
    t_out               c12_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c12_rnd[i] = r11_prod[i] + 66'h0_8000_0000;
            c12_hit[i] = r11_side.vr[i][32]
                       ? (r11_side.s[i] - c12_rnd[i][63:32])
                       : (r11_side.s[i] + c12_rnd[i][63:32]);
            c12_end[i] = r11_side.s[i] + r11_side.vr[i][31:0];
        end
        c12_out = '0;
        case (r11_side.kind)
            K_NONE: begin
                c12_out.status = ST_NONE;
            end
            K_FAULT: begin
                c12_out.status = ST_FAULT;
            end
            K_START: begin
                c12_out.status = ST_HIT;
                c12_out.hit_x  = r11_side.s[0];
                c12_out.hit_y  = r11_side.s[1];
                c12_out.hit_z  = r11_side.s[2];
            end
            K_END: begin
                c12_out.status = ST_HIT;
                c12_out.hit_x  = c12_end[0];
                c12_out.hit_y  = c12_end[1];
                c12_out.hit_z  = c12_end[2];
            end
            default: begin
                c12_out.status = ST_HIT;
                c12_out.hit_x  = c12_hit[0];
                c12_out.hit_y  = c12_hit[1];
                c12_out.hit_z  = c12_hit[2];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r11_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= c12_out;
        end
    end

    // ---------------- checks
    a_zero_hit_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_HIT) |->
        (o_out_data.hit_x == '0 && o_out_data.hit_y == '0 && o_out_data.hit_z == '0))
        else $error("non-crossing result carries a nonzero point");

    a_frozen_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> ($stable(r1_v) && $stable(r8_v) && $stable(r11_v)))
        else $error("pipeline moved while the output was held");

    a_num_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r8_v && r8_side.kind == K_INTERP) |-> (r8_num <= r8_a))
        else $error("selected numerator lies outside the segment");

    a_param_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dv_v && dv_side.kind == K_INTERP) |-> (dv_q <= 33'h1_0000_0000))
        else $error("segment parameter above one");

endmodule

// ----- bench/sphere_segment_intersect_tb.sv -----
// self-checking bench for the sphere/segment crossing pipeline
`timescale 1ns / 1ps

module sphere_segment_intersect_tb;
    import ssi_pkg::*;

    // index outside the register map, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
    localparam int    N_PHASES     = 6;
    localparam int    ITEMS_PHASE  = 255;
    localparam int    DRAIN_CYCLES = 130;
    localparam longint SLACK_LIMIT = 64'd180143985094819;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    // bench copy of the sphere registers
    longint sph_cx, sph_cy, sph_cz, sph_radius, sph_tol;

    t_in  pending_segs[$];
    t_out expected_hits[$];
    int   mismatches = 0;
    int   in_gap = 0;
    int   out_gap = 0;
    bit   quiet = 1'b0;

    sphere_segment_intersect u_dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic longint sx32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic bit point_in_sphere(longint px, longint py, longint pz);
        longint p[3], c[3], dx, span;
        logic signed [127:0] dw, d2, lim;
        p[0] = px; p[1] = py; p[2] = pz;
        c[0] = sph_cx; c[1] = sph_cy; c[2] = sph_cz;
        span = sph_radius + 655;
        d2 = 0;
        for (int i = 0; i < 3; i++) begin
            dx = p[i] - c[i];
            if (dx < -span || dx > span) return 1'b0;
            dw = dx;
            d2 += dw * dw;
        end
        lim = (128'(sph_radius) * 128'(sph_radius)) + (128'(sph_tol) << 16);
        return d2 <= lim;
    endfunction

    // expected result of one segment against the current sphere
    function automatic t_out predict_crossing(t_in seg);
        longint s[3], e[3], c[3], vr;
        logic signed [127:0] a, h, cc, rq, dq, vq, disc, root, t, np, nm, num, dp, dm;
        logic [63:0] ua, un, lq, mg, dmag;
        logic [31:0] hv[3];
        t_out res;
        s[0] = sx32(seg.start_x); s[1] = sx32(seg.start_y); s[2] = sx32(seg.start_z);
        e[0] = sx32(seg.end_x);   e[1] = sx32(seg.end_y);   e[2] = sx32(seg.end_z);
        c[0] = sph_cx; c[1] = sph_cy; c[2] = sph_cz;
        res = '0;
        res.status = ST_NONE;
        if (point_in_sphere(s[0], s[1], s[2]) == point_in_sphere(e[0], e[1], e[2]))
            return res;

        a = 0; h = 0; cc = 0;
        rq = sph_radius >>> 2;
        for (int i = 0; i < 3; i++) begin
            dq = (s[i] - c[i]) >>> 2;
            vq = (e[i] - s[i]) >>> 2;
            a += vq * vq;
            h += dq * vq;
            cc += dq * dq;
        end
        cc -= rq * rq;
        res.status = ST_HIT;
        for (int i = 0; i < 3; i++) hv[i] = s[i][31:0];

        if (a != 0) begin
            disc = h * h - a * cc;
            if (disc < 0) begin
                // tangent within slack counts as a touch, beyond it is a fault
                if (-disc > SLACK_LIMIT) begin
                    res.status = ST_FAULT;
                    return res;
                end
                disc = 0;
            end
            root = 0;
            for (int b = 62; b >= 0; b--) begin
                t = root | (128'sd1 <<< b);
                if (t * t <= disc) root = t;
            end
            np = -h + root;
            nm = -h - root;
            if (np >= 0 && np <= a) num = np;
            else if (nm >= 0 && nm <= a) num = nm;
            else begin
                // no root in range, snap to the nearer endpoint
                dp = np < 0 ? -np : np - a;
                dm = nm < 0 ? -nm : nm - a;
                num = dp < dm ? np : nm;
                for (int i = 0; i < 3; i++) hv[i] = (num > a) ? e[i][31:0] : s[i][31:0];
                num = -1;
            end
            if (num >= 0) begin
                ua = a[63:0];
                un = num[63:0];
                while (ua > 64'hFFFF_FFFF) begin
                    ua >>= 1;
                    un >>= 1;
                end
                lq = (un << 32) / ua;
                for (int i = 0; i < 3; i++) begin
                    vr = e[i] - s[i];
                    mg = vr < 0 ? 64'(-vr) : 64'(vr);
                    dmag = (lq * mg + 64'h8000_0000) >> 32;
                    hv[i] = vr < 0 ? 32'(s[i] - dmag) : 32'(s[i] + dmag);
                end
            end
        end
        res.hit_x = hv[0];
        res.hit_y = hv[1];
        res.hit_z = hv[2];
        return res;
    endfunction

    // input driver: one segment per transfer, random idle bursts between
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_stall) begin
            // hold the stalled transfer as it is
        end else begin
            if (i_in_valid) begin
                expected_hits.push_back(predict_crossing(pending_segs.pop_front()));
                if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 6);
            end
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_segs.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_segs[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall pattern, bursty, switched off in the last phase
    always @(posedge i_clk) begin
        if (out_gap > 0) begin
            out_gap--;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            out_gap = $urandom_range(0, 5);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %p", o_out_data);
            end else begin
                want = expected_hits.pop_front();
                if (o_out_data.status !== want.status || o_out_data.hit_x !== want.hit_x ||
                    o_out_data.hit_y !== want.hit_y || o_out_data.hit_z !== want.hit_z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected st=%0d hit=%h %h %h, got st=%0d hit=%h %h %h",
                                 want.status, want.hit_x, want.hit_y, want.hit_z,
                                 o_out_data.status, o_out_data.hit_x, o_out_data.hit_y,
                                 o_out_data.hit_z);
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_CENTRE_X: sph_cx = sx32(val);
            CFG_CENTRE_Y: sph_cy = sx32(val);
            CFG_CENTRE_Z: sph_cz = sx32(val);
            CFG_RADIUS:   sph_radius = val[30:0];
            CFG_TOL:      sph_tol = val[30:0];
            default: ;
        endcase
    endtask

    task automatic load_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [31:0] rad, logic [31:0] tol);
        @(posedge i_clk);
        write_reg(CFG_CENTRE_X, cx);
        write_reg(CFG_CENTRE_Y, cy);
        write_reg(CFG_CENTRE_Z, cz);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_TOL, tol);
        write_reg(CFG_UNMAPPED, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_segs.size() != 0 || expected_hits.size() != 0 || i_in_valid);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic longint near_offset(longint r);
        longint span;
        span = r / 2;
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    function automatic longint far_offset(longint r);
        longint m;
        m = r + 1 + longint'($urandom_range(0, 32'(2 * r + 700)));
        return $urandom_range(0, 1) ? m : -m;
    endfunction

    // random segment with one end inside the sphere and one outside
    function automatic t_in crossing_seg();
        t_in sg;
        longint r;
        r = sph_radius > 64'h3FFF_FFFF ? 64'h3FFF_FFFF : sph_radius;
        sg.start_x = 32'(sph_cx + near_offset(r));
        sg.start_y = 32'(sph_cy + near_offset(r));
        sg.start_z = 32'(sph_cz + near_offset(r));
        sg.end_x   = 32'(sph_cx + far_offset(r));
        sg.end_y   = 32'(sph_cy + near_offset(r));
        sg.end_z   = 32'(sph_cz + far_offset(r));
        if ($urandom_range(0, 1)) sg = {sg.end_x, sg.end_y, sg.end_z,
                                        sg.start_x, sg.start_y, sg.start_z};
        return sg;
    endfunction

    function automatic t_in random_seg();
        t_in sg;
        longint r;
        r = sph_radius > 64'h3FFF_FFFF ? 64'h3FFF_FFFF : sph_radius;
        case ($urandom_range(0, 9))
            0, 1: begin
                sg = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            end
            2: begin
                // both ends near the centre, often both inside
                sg.start_x = 32'(sph_cx + near_offset(r));
                sg.start_y = 32'(sph_cy + near_offset(r));
                sg.start_z = 32'(sph_cz + near_offset(r));
                sg.end_x   = 32'(sph_cx + near_offset(r));
                sg.end_y   = 32'(sph_cy + near_offset(r));
                sg.end_z   = 32'(sph_cz + near_offset(r));
            end
            default: sg = crossing_seg();
        endcase
        return sg;
    endfunction

    initial begin
        t_in sg;
        logic [31:0] cfg_tab[N_PHASES][5];
        cfg_tab[0] = '{32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0};
        cfg_tab[1] = '{32'h0064_8000, 32'hFFFD_0000, 32'h0007_0000, 32'h000A_0000, 32'h100};
        cfg_tab[2] = '{32'h7FFF_0000, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        cfg_tab[3] = '{$urandom, $urandom, $urandom, 32'h0, 32'h0};
        cfg_tab[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 32'h4, $urandom_range(0, 64)};
        cfg_tab[5] = '{$urandom_range(0, 32'h00FF_FFFF), $urandom_range(0, 32'h00FF_FFFF),
                       $urandom_range(0, 32'h00FF_FFFF), $urandom_range(1, 32'h0010_0000),
                       $urandom_range(0, 4096)};
        sph_cx = 0; sph_cy = 0; sph_cz = 0; sph_radius = 65536; sph_tol = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes and the named corner cases at the default sphere
        load_sphere(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
        pending_segs.push_back({6{32'h8000_0000}});
        pending_segs.push_back({6{32'h7FFF_FFFF}});
        pending_segs.push_back({32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        pending_segs.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0});
        // straight out along x, exact crossing at 1.0
        pending_segs.push_back({32'h0, 32'h0, 32'h0, 32'h0002_0000, 32'h0, 32'h0});
        pending_segs.push_back({32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        // degenerate direction: on the surface then one quantum outside
        pending_segs.push_back({32'h0001_0000, 32'h0, 32'h0, 32'h0001_0001, 32'h0, 32'h0});
        pending_segs.push_back({32'h0001_0001, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0});
        // inside the slack box but outside the sphere: tangent and fault paths
        pending_segs.push_back({32'h0001_0100, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        pending_segs.push_back({32'h0, 32'h0000_FF00, 32'h0, 32'h0, 32'h0001_0200, 32'h0});
        pending_segs.push_back({32'h0000_B500, 32'h0000_B500, 32'h0, 32'h0000_B600,
                                32'h0000_B600, 32'h0});
        // both inside, both outside
        pending_segs.push_back({32'h0, 32'h0, 32'h0, 32'h0000_8000, 32'h0000_8000, 32'h0});
        pending_segs.push_back({32'h0005_0000, 32'h0, 32'h0, 32'h0006_0000, 32'h0, 32'h0});
        wait_drained();
        // directed: extreme radius and tolerance, zero radius
        load_sphere(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        pending_segs.push_back({32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        pending_segs.push_back({32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        pending_segs.push_back({32'h7FFF_0000, 32'h0000_1000, 32'h0, 32'h8000_0000, 32'h0, 32'h0});
        wait_drained();
        load_sphere(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        pending_segs.push_back({32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0});
        pending_segs.push_back({32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        wait_drained();

        // random phases over several spheres, the last without idling
        for (int p = 0; p < N_PHASES; p++) begin
            load_sphere(cfg_tab[p][0], cfg_tab[p][1], cfg_tab[p][2], cfg_tab[p][3],
                        cfg_tab[p][4]);
            if (p == N_PHASES - 1) quiet = 1'b1;
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                sg = random_seg();
                pending_segs.push_back(sg);
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("sphere_segment_intersect_tb: PASS");
        else
            $display("sphere_segment_intersect_tb: FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("sphere_segment_intersect_tb: FAIL");
        $finish;
    end

endmodule
